// ===== rtl/mrd_pkg.sv =====
package mrd_pkg;

   localparam int BYTE_W = 8;
   localparam int CRC_W = 16;
   localparam int WORD_W = 32;
   localparam int WIDX_W = 3;
   localparam int CSR_IDX_W = 8;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
   localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;

   localparam logic [BYTE_W-1:0] STATION_RST = 8'h01;
   localparam logic [BYTE_W-1:0] FUNCTION_RST = 8'h03;

   // register indexes on the CSR channel
   localparam logic [CSR_IDX_W-1:0] CSR_STATION = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FUNCTION = 8'd1;

   typedef enum logic [1:0] {
      RS_DATA     = 2'd0,
      RS_CRC_ERR  = 2'd1,
      RS_OVERFLOW = 2'd2,
      RS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      PH_ADDR   = 6'b000001,
      PH_FUNC   = 6'b000010,
      PH_COUNT  = 6'b000100,
      PH_DATA   = 6'b001000,
      PH_CRC_LO = 6'b010000,
      PH_CRC_HI = 6'b100000
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PROC = 4'b0010,
      S_CRC  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   // command to the serial CRC unit
   typedef struct packed {
      logic start;
      logic seed;
   } crc_ctrl_type;

endpackage

// ===== rtl/mrd_intf.sv =====
interface mrd_req_if;
   import mrd_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, kind, rx_byte, input ready);
   modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface mrd_rsp_if;
   import mrd_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [WIDX_W-1:0] word_index;
   logic [WORD_W-1:0] word_value;
   logic              last;

   modport source (output valid, status, word_index, word_value, last, input ready);
   modport sink (input valid, status, word_index, word_value, last, output ready);
endinterface

interface mrd_csr_if;
   import mrd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/mrd_crc_serial.sv =====
module mrd_crc_serial (
   input  logic                  clock,
   input  logic                  reset,
   input  mrd_pkg::crc_ctrl_type ctrl,
   input  logic [7:0]            data,
   output logic [15:0]           crc,
   output logic                  busy
);
   import mrd_pkg::*;

   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0] sh_ff, sh_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              fb;

   // one reflected CRC bit per cycle
   always_comb begin
      crc_in = crc_ff;
      sh_in = sh_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      fb = crc_ff[0] ^ sh_ff[0];
      if (ctrl.start) begin
         crc_in = ctrl.seed ? CRC_SEED : crc_ff;
         sh_in = data;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         crc_in = {1'b0, crc_ff[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
         sh_in = {1'b0, sh_ff[BYTE_W-1:1]};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_SEED;
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   // shift data needs no reset
   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
   end

   assign crc = crc_ff;
   assign busy = busy_ff;

   property p_no_start_busy;
      @(posedge clock) disable iff (reset) ctrl.start |-> !busy_ff;
   endproperty
   a_no_start_busy: assert property (p_no_start_busy)
      else $error("crc start while busy");

   property p_eight_steps;
      @(posedge clock) disable iff (reset) ctrl.start |=> ##7 busy_ff;
   endproperty
   a_eight_steps: assert property (p_eight_steps)
      else $error("crc finished early");

   property p_done_after_eight;
      @(posedge clock) disable iff (reset) ctrl.start |=> ##8 !busy_ff;
   endproperty
   a_done_after_eight: assert property (p_done_after_eight)
      else $error("crc ran too long");
endmodule

// ===== rtl/mrd_word_store.sv =====
module mrd_word_store #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== rtl/modbus_read_response_deframer_core.sv =====
// Each received byte is accepted, decoded by header/phase, then run through the bit-serial CRC,
// and the core waits in S_CRC to see the CRC unit finish.
// CRC low byte and hunt misses go back to idle straight after decode; a restart stays in idle.
// The final CRC byte goes from decode to emit, which loads one
// result per cycle as the sink takes them; the next byte is taken after the last is loaded.
// Synchronous active-high reset: hunt for address, station 0x01, function 0x03.
module modbus_read_response_deframer_core #(
   parameter int MAX_WORDS = 8
) (
   input logic       clock,
   input logic       reset,
   mrd_req_if.sink   req_ch,
   mrd_rsp_if.source rsp_ch,
   mrd_csr_if.sink   csr_ch
);
   import mrd_pkg::*;

   localparam int WORD_CAP = (MAX_WORDS < 8) ? MAX_WORDS : 8;
   localparam int IDX_W = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;
   localparam int MAX_BYTES = 4 * WORD_CAP;
   localparam int LEN_W = $clog2(MAX_BYTES + 1);

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  seen_ff, seen_in;
   logic [LEN_W-1:0]  seen_next;
   logic [BYTE_W-1:0] crc_lo_ff, crc_lo_in;
   logic [BYTE_W-1:0] station_ff, station_in;
   logic [BYTE_W-1:0] func_ff, func_in;
   logic [WORD_W-1:0] asm_ff, asm_in;
   status_type        res_status_ff, res_status_in;
   logic [WIDX_W-1:0] last_idx_ff, last_idx_in;
   logic [WIDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WIDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   crc_ctrl_type      crc_ctrl;
   logic [CRC_W-1:0]  crc_value;
   logic              crc_busy;
   logic              st_wr_en;
   logic [WORD_W-1:0] st_rd_data;

   assign seen_next = seen_ff + LEN_W'(1);

   mrd_crc_serial u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .data  (byte_ff),
      .crc   (crc_value),
      .busy  (crc_busy)
   );

   // read address follows the next emit index so the registered word is ready in time
   mrd_word_store #(
      .WIDTH  (WORD_W),
      .DEPTH  (WORD_CAP),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (IDX_W'(seen_ff >> 2)),
      .wr_data (asm_in),
      .rd_addr (emit_idx_in[IDX_W-1:0]),
      .rd_data (st_rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.word_index = rsp_index_ff;
   assign rsp_ch.word_value = rsp_value_ff;
   assign rsp_ch.last = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      byte_in = byte_ff;
      len_in = len_ff;
      seen_in = seen_ff;
      crc_lo_in = crc_lo_ff;
      station_in = station_ff;
      func_in = func_ff;
      asm_in = asm_ff;
      res_status_in = res_status_ff;
      last_idx_in = last_idx_ff;
      emit_idx_in = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in = rsp_last_ff;
      crc_ctrl = '0;
      st_wr_en = 1'b0;

      // take register writes
      if (csr_ch.valid) begin
         if (csr_ch.index == CSR_STATION) begin
            station_in = csr_ch.wdata;
         end else if (csr_ch.index == CSR_FUNCTION) begin
            func_in = csr_ch.wdata;
         end
      end

      // drop the held result once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               byte_in = req_ch.rx_byte;
               if (req_ch.kind) begin
                  phase_in = PH_ADDR;
                  len_in = '0;
                  seen_in = '0;
                  crc_lo_in = '0;
               end else begin
                  state_in = S_PROC;
               end
            end
         end

         S_PROC: begin
            state_in = S_IDLE;
            unique case (phase_ff)
               PH_ADDR: begin
                  if (byte_ff == station_ff) begin
                     crc_ctrl.start = 1'b1;
                     crc_ctrl.seed = 1'b1;
                     phase_in = PH_FUNC;
                     state_in = S_CRC;
                  end
               end
               PH_FUNC: begin
                  if (byte_ff == func_ff) begin
                     crc_ctrl.start = 1'b1;
                     phase_in = PH_COUNT;
                     state_in = S_CRC;
                  end else if (byte_ff == station_ff) begin
                     // repeated address restarts the header at this byte
                     crc_ctrl.start = 1'b1;
                     crc_ctrl.seed = 1'b1;
                     state_in = S_CRC;
                  end else begin
                     phase_in = PH_ADDR;
                     len_in = '0;
                     seen_in = '0;
                     crc_lo_in = '0;
                  end
               end
               PH_COUNT: begin
                  if (byte_ff > BYTE_W'(MAX_BYTES)) begin
                     res_status_in = RS_OVERFLOW;
                     state_in = S_EMIT;
                     phase_in = PH_ADDR;
                     len_in = '0;
                     seen_in = '0;
                     crc_lo_in = '0;
                  end else begin
                     crc_ctrl.start = 1'b1;
                     len_in = LEN_W'(byte_ff);
                     seen_in = '0;
                     phase_in = (byte_ff == '0) ? PH_CRC_LO : PH_DATA;
                     state_in = S_CRC;
                  end
               end
               PH_DATA: begin
                  // place the byte in its lane; the first byte of a word clears the rest
                  if (seen_ff[1:0] == 2'd0) begin
                     asm_in = {byte_ff, 24'd0};
                  end else begin
                     asm_in[BYTE_W*(3 - int'(seen_ff[1:0])) +: BYTE_W] = byte_ff;
                  end
                  st_wr_en = 1'b1;
                  crc_ctrl.start = 1'b1;
                  seen_in = seen_next;
                  if (seen_next >= len_ff) begin
                     phase_in = PH_CRC_LO;
                  end
                  state_in = S_CRC;
               end
               PH_CRC_LO: begin
                  crc_lo_in = byte_ff;
                  phase_in = PH_CRC_HI;
               end
               PH_CRC_HI: begin
                  if ({byte_ff, crc_lo_ff} != crc_value) begin
                     res_status_in = RS_CRC_ERR;
                  end else if (len_ff == '0) begin
                     res_status_in = RS_EMPTY;
                  end else begin
                     res_status_in = RS_DATA;
                  end
                  last_idx_in = WIDX_W'(LEN_W'(len_ff - LEN_W'(1)) >> 2);
                  emit_idx_in = '0;
                  state_in = S_EMIT;
                  phase_in = PH_ADDR;
                  len_in = '0;
                  seen_in = '0;
                  crc_lo_in = '0;
               end
               default: begin
                  phase_in = PH_ADDR;
                  len_in = '0;
                  seen_in = '0;
                  crc_lo_in = '0;
               end
            endcase
         end

         S_CRC: begin
            if (!crc_busy) begin
               state_in = S_IDLE;
            end
         end

         S_EMIT: begin
            // load the next result when the output slot frees
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               if (res_status_ff == RS_DATA) begin
                  rsp_index_in = emit_idx_ff;
                  rsp_value_in = st_rd_data;
                  rsp_last_in = (emit_idx_ff == last_idx_ff);
                  emit_idx_in = emit_idx_ff + WIDX_W'(1);
                  if (emit_idx_ff == last_idx_ff) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  rsp_index_in = '0;
                  rsp_value_in = '0;
                  rsp_last_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_ADDR;
         len_ff <= '0;
         seen_ff <= '0;
         crc_lo_ff <= '0;
         station_ff <= STATION_RST;
         func_ff <= FUNCTION_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         len_ff <= len_in;
         seen_ff <= seen_in;
         crc_lo_ff <= crc_lo_in;
         station_ff <= station_in;
         func_ff <= func_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      asm_ff <= asm_in;
      res_status_ff <= res_status_in;
      last_idx_ff <= last_idx_in;
      emit_idx_ff <= emit_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff <= rsp_last_in;
   end

   property p_ready_crc_idle;
      @(posedge clock) disable iff (reset) req_ch.ready |-> !crc_busy;
   endproperty
   a_ready_crc_idle: assert property (p_ready_crc_idle)
      else $error("request taken while crc busy");

   property p_error_is_last;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_status_ff != RS_DATA) |-> (rsp_last_ff && rsp_value_ff == '0);
   endproperty
   a_error_is_last: assert property (p_error_is_last)
      else $error("non-data result not final or not zero");

   property p_crc_from_decode;
      @(posedge clock) disable iff (reset) $rose(crc_busy) |-> $past(state_ff == S_PROC);
   endproperty
   a_crc_from_decode: assert property (p_crc_from_decode)
      else $error("crc started outside decode");

   property p_store_write_phase;
      @(posedge clock) disable iff (reset)
         st_wr_en |-> (phase_ff == PH_DATA && state_ff == S_PROC && seen_ff < len_ff);
   endproperty
   a_store_write_phase: assert property (p_store_write_phase)
      else $error("store written outside data phase");
endmodule
